[rtl/core/mqdf_pkg.sv]
package mqdf_pkg;

    // Remaining-length field: at most this many base-128 bytes.
    localparam int MAX_LENGTH_BYTES = 4;
    // Groups that fit the 28-bit accumulator.
    localparam int LEN_GROUPS       = 4;

    localparam int LEN_W    = 28;
    localparam int TOPIC_W  = 16;
    localparam int LCNT_W   = 3;

    localparam logic [3:0] KIND_PUBLISH = 4'h3;

    typedef enum logic [2:0] {
        PH_TYPE    = 3'd0,
        PH_LEN     = 3'd1,
        PH_TLHI    = 3'd2,
        PH_TLLO    = 3'd3,
        PH_TOPIC   = 3'd4,
        PH_ID      = 3'd5,
        PH_PAYLOAD = 3'd6,
        PH_OTHER   = 3'd7
    } t_phase;

    typedef enum logic [2:0] {
        ROLE_TYPE    = 3'd0,
        ROLE_LEN     = 3'd1,
        ROLE_TLHI    = 3'd2,
        ROLE_TLLO    = 3'd3,
        ROLE_TOPIC   = 3'd4,
        ROLE_ID      = 3'd5,
        ROLE_PAYLOAD = 3'd6,
        ROLE_OTHER   = 3'd7
    } t_role;

    typedef enum logic [1:0] {
        FAULT_NONE    = 2'd0,
        FAULT_LEN     = 2'd1,
        FAULT_PUB_CUT = 2'd2
    } t_fault;

endpackage

[rtl/core/mqdf_if.sv]
interface mqdf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mqdf_out_if;
    logic                        valid;
    logic                        ready;
    logic [7:0]                  out_byte;
    logic [2:0]                  role;
    logic [3:0]                  packet_kind;
    logic [1:0]                  pub_qos;
    logic [mqdf_pkg::LEN_W-1:0]  body_length;
    logic                        last;
    logic [1:0]                  fault;

    modport source (
        output valid, output out_byte, output role, output packet_kind,
        output pub_qos, output body_length, output last, output fault,
        input ready
    );
    modport sink (
        input valid, input out_byte, input role, input packet_kind,
        input pub_qos, input body_length, input last, input fault,
        output ready
    );
endinterface

[rtl/core/mqtt_packet_deframer_top.sv]
// Output: an accepted byte is registered and appears on o_res in the cycle after it is accepted.
// Throughput: one byte per cycle while o_res.ready is high; the byte is accepted while the held result
// drains, since the result register empties and refills at the same edge.
// Reset: synchronous, active low; the framer waits for a type byte and the
// result register is empty.
module mqtt_packet_deframer_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mqdf_in_if.sink           i_rx,
    mqdf_out_if.source        o_res
);

    localparam int LEN_W   = mqdf_pkg::LEN_W;
    localparam int TOPIC_W = mqdf_pkg::TOPIC_W;
    localparam int LCNT_W  = mqdf_pkg::LCNT_W;

    // Framing state.
    mqdf_pkg::t_phase    r_phase, n_phase;
    logic [7:0]          r_type, n_type;
    logic [LEN_W-1:0]    r_acc, n_acc;
    logic [LCNT_W-1:0]   r_cnt, n_cnt;
    logic [LEN_W-1:0]    r_body, n_body;
    logic [TOPIC_W-1:0]  r_tlen, n_tlen;
    logic [TOPIC_W-1:0]  r_tleft, n_tleft;
    logic [1:0]          r_id, n_id;

    // Result register.
    logic                r_out_valid;
    logic [7:0]          r_out_byte;
    mqdf_pkg::t_role     r_role, n_role;
    logic                r_last, n_last;
    mqdf_pkg::t_fault    r_fault, n_fault;
    logic [3:0]          r_kind;
    logic [1:0]          r_qos;
    logic [LEN_W-1:0]    r_blen;

    logic                w_accept;
    logic [7:0]          w_b;
    logic [LEN_W-1:0]    w_body_dec;
    logic [TOPIC_W-1:0]  w_tleft_dec;
    logic [1:0]          w_id_dec;
    logic [LEN_W-1:0]    w_group;
    logic [4:0]          w_shift;
    logic [LEN_W-1:0]    w_acc_new;
    logic [LCNT_W-1:0]   w_cnt_inc;
    logic [TOPIC_W-1:0]  w_tlen_full;
    logic                w_qos_nz;
    logic                w_is_pub;
    logic                w_ends;

    // Accept a byte whenever the result slot is empty or being drained.
    assign i_rx.ready = !r_out_valid || o_res.ready;
    assign w_accept   = i_rx.valid && i_rx.ready;
    assign w_b        = i_rx.rx_byte;

    assign w_body_dec  = r_body - LEN_W'(1);
    assign w_tleft_dec = r_tleft - TOPIC_W'(1);
    assign w_id_dec    = r_id - 2'd1;
    assign w_qos_nz    = (r_type[2:1] != 2'd0);
    assign w_is_pub    = (r_type[7:4] == mqdf_pkg::KIND_PUBLISH);
    assign w_cnt_inc   = r_cnt + LCNT_W'(1);
    assign w_tlen_full = r_tlen | TOPIC_W'(w_b);

    // Base-128 group: least significant group first, 7 bits per length byte.
    assign w_shift   = 5'd7 * {3'b000, r_cnt[1:0]};
    assign w_group   = LEN_W'(w_b[6:0]) << w_shift;
    assign w_acc_new = (r_cnt < LCNT_W'(mqdf_pkg::LEN_GROUPS)) ? (r_acc + w_group) : r_acc;

    always_comb begin
        n_phase = r_phase;
        n_type  = r_type;
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        n_body  = r_body;
        n_tlen  = r_tlen;
        n_tleft = r_tleft;
        n_id    = r_id;
        n_role  = mqdf_pkg::ROLE_TYPE;
        n_last  = 1'b0;
        n_fault = mqdf_pkg::FAULT_NONE;
        w_ends  = 1'b0;

        unique case (r_phase)
            mqdf_pkg::PH_TYPE: begin
                n_role  = mqdf_pkg::ROLE_TYPE;
                n_type  = w_b;
                n_acc   = '0;
                n_cnt   = '0;
                n_phase = mqdf_pkg::PH_LEN;
            end
            mqdf_pkg::PH_LEN: begin
                n_role = mqdf_pkg::ROLE_LEN;
                n_acc  = w_acc_new;
                n_cnt  = w_cnt_inc;
                if (w_b[7]) begin
                    // Continuation past the last allowed byte: abort and resync.
                    if (w_cnt_inc >= LCNT_W'(mqdf_pkg::MAX_LENGTH_BYTES)) begin
                        n_last  = 1'b1;
                        n_fault = mqdf_pkg::FAULT_LEN;
                        n_phase = mqdf_pkg::PH_TYPE;
                    end
                end else if (w_acc_new == '0) begin
                    // Empty body ends the packet here.
                    n_last  = 1'b1;
                    if (w_is_pub) begin
                        n_fault = mqdf_pkg::FAULT_PUB_CUT;
                    end
                    n_phase = mqdf_pkg::PH_TYPE;
                end else begin
                    n_body  = w_acc_new;
                    n_phase = w_is_pub ? mqdf_pkg::PH_TLHI : mqdf_pkg::PH_OTHER;
                end
            end
            mqdf_pkg::PH_TLHI: begin
                n_role = mqdf_pkg::ROLE_TLHI;
                n_tlen = {w_b, 8'h00};
                n_body = w_body_dec;
                if (w_body_dec == '0) begin
                    w_ends  = 1'b1;
                    n_fault = mqdf_pkg::FAULT_PUB_CUT;
                end else begin
                    n_phase = mqdf_pkg::PH_TLLO;
                end
            end
            mqdf_pkg::PH_TLLO: begin
                n_role  = mqdf_pkg::ROLE_TLLO;
                n_tlen  = w_tlen_full;
                n_tleft = w_tlen_full;
                n_body  = w_body_dec;
                if (w_body_dec == '0) begin
                    w_ends = 1'b1;
                    if (w_tlen_full != '0 || w_qos_nz) begin
                        n_fault = mqdf_pkg::FAULT_PUB_CUT;
                    end
                end else if (w_tlen_full != '0) begin
                    n_phase = mqdf_pkg::PH_TOPIC;
                end else if (w_qos_nz) begin
                    n_id    = 2'd2;
                    n_phase = mqdf_pkg::PH_ID;
                end else begin
                    n_phase = mqdf_pkg::PH_PAYLOAD;
                end
            end
            mqdf_pkg::PH_TOPIC: begin
                n_role  = mqdf_pkg::ROLE_TOPIC;
                n_tleft = w_tleft_dec;
                n_body  = w_body_dec;
                if (w_body_dec == '0) begin
                    w_ends = 1'b1;
                    if (w_tleft_dec != '0 || w_qos_nz) begin
                        n_fault = mqdf_pkg::FAULT_PUB_CUT;
                    end
                end else if (w_tleft_dec == '0) begin
                    if (w_qos_nz) begin
                        n_id    = 2'd2;
                        n_phase = mqdf_pkg::PH_ID;
                    end else begin
                        n_phase = mqdf_pkg::PH_PAYLOAD;
                    end
                end
            end
            mqdf_pkg::PH_ID: begin
                n_role = mqdf_pkg::ROLE_ID;
                n_id   = w_id_dec;
                n_body = w_body_dec;
                if (w_body_dec == '0) begin
                    w_ends = 1'b1;
                    if (w_id_dec != 2'd0) begin
                        n_fault = mqdf_pkg::FAULT_PUB_CUT;
                    end
                end else if (w_id_dec == 2'd0) begin
                    n_phase = mqdf_pkg::PH_PAYLOAD;
                end
            end
            mqdf_pkg::PH_PAYLOAD: begin
                n_role = mqdf_pkg::ROLE_PAYLOAD;
                n_body = w_body_dec;
                w_ends = (w_body_dec == '0);
            end
            mqdf_pkg::PH_OTHER: begin
                n_role = mqdf_pkg::ROLE_OTHER;
                n_body = w_body_dec;
                w_ends = (w_body_dec == '0);
            end
            default: begin
                n_phase = mqdf_pkg::PH_TYPE;
            end
        endcase

        // Body exhausted: mark the byte and go back to the type byte.
        if (w_ends) begin
            n_last  = 1'b1;
            n_phase = mqdf_pkg::PH_TYPE;
        end
    end

    // Advance the framing state only on a transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= mqdf_pkg::PH_TYPE;
            r_type  <= '0;
            r_acc   <= '0;
            r_cnt   <= '0;
            r_body  <= '0;
            r_tlen  <= '0;
            r_tleft <= '0;
            r_id    <= '0;
        end else if (w_accept) begin
            r_phase <= n_phase;
            r_type  <= n_type;
            r_acc   <= n_acc;
            r_cnt   <= n_cnt;
            r_body  <= n_body;
            r_tlen  <= n_tlen;
            r_tleft <= n_tleft;
            r_id    <= n_id;
        end
    end

    // Result slot: fill on a transfer in, empty on a transfer out.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_byte <= w_b;
            r_role     <= n_role;
            r_last     <= n_last;
            r_fault    <= n_fault;
            r_kind     <= n_type[7:4];
            r_qos      <= n_type[2:1];
            r_blen     <= n_acc;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.out_byte    = r_out_byte;
    assign o_res.role        = r_role;
    assign o_res.packet_kind = r_kind;
    assign o_res.pub_qos     = r_qos;
    assign o_res.body_length = r_blen;
    assign o_res.last        = r_last;
    assign o_res.fault       = r_fault;

    // A fault only ever rides on the closing byte of a packet.
    a_fault_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_fault != mqdf_pkg::FAULT_NONE) |-> r_last)
        else $error("fault reported without last");

    // A closing byte sends the framer back to the type byte.
    a_last_resyncs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && n_last |=> r_phase == mqdf_pkg::PH_TYPE)
        else $error("framer did not return to type byte after last");

    // The length byte counter never runs past the field limit.
    a_len_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= LCNT_W'(mqdf_pkg::MAX_LENGTH_BYTES))
        else $error("length byte counter overran");

    // A type byte restarts the length decode.
    a_type_clears_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_role == mqdf_pkg::ROLE_TYPE) |-> (r_blen == '0) && !r_last)
        else $error("type byte carried a length or last");

    // Body bytes are only counted while a body is open.
    a_body_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != mqdf_pkg::PH_TYPE) && (r_phase != mqdf_pkg::PH_LEN) |-> (r_body != '0))
        else $error("body phase with no bytes left");

endmodule
